// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the pulse decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on the standard clk_i / rst_ni pair.
`define ASSERT_PORT(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: hdl/irpd_pkg.sv
// Types, codes and reset constants for the IR remote pulse decoder.
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

  localparam int unsigned CodeBitsDefault = 32;
  localparam int unsigned CodeWordWidth   = 32;
  localparam int unsigned WidthBits       = 16;
  localparam int unsigned CfgIndexBits    = 3;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] CfgZeroMin = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgZeroMax = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgOneMin  = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgOneMax  = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgEndMin  = 3'd4;
  localparam logic [CfgIndexBits-1:0] CfgEndMax  = 3'd5;
  localparam logic [CfgIndexBits-1:0] CfgSyncMin = 3'd6;
  localparam logic [CfgIndexBits-1:0] CfgSyncMax = 3'd7;

  // Reset values of the window bounds, in timer ticks
  localparam logic [WidthBits-1:0] ZeroMinReset = 16'd25;
  localparam logic [WidthBits-1:0] ZeroMaxReset = 16'd55;
  localparam logic [WidthBits-1:0] OneMinReset  = 16'd100;
  localparam logic [WidthBits-1:0] OneMaxReset  = 16'd140;
  localparam logic [WidthBits-1:0] EndMinReset  = 16'd155;
  localparam logic [WidthBits-1:0] EndMaxReset  = 16'd200;
  localparam logic [WidthBits-1:0] SyncMinReset = 16'd300;
  localparam logic [WidthBits-1:0] SyncMaxReset = 16'd450;

  typedef enum logic [2:0] {
    KindRise = 3'd0,
    KindZero = 3'd1,
    KindOne  = 3'd2,
    KindEnd  = 3'd3,
    KindSync = 3'd4,
    KindMiss = 3'd5
  } pulse_kind_e;

  typedef struct packed {
    logic [WidthBits-1:0] capture_count;
    logic                 ack_done;
  } in_item_t;

  typedef struct packed {
    logic [CodeWordWidth-1:0] code_word;
    logic                     frame_done;
    logic                     sync_armed;
    logic [2:0]               pulse_kind;
  } out_item_t;

  // Window bounds, all exclusive at both ends
  typedef struct packed {
    logic [WidthBits-1:0] zero_min;
    logic [WidthBits-1:0] zero_max;
    logic [WidthBits-1:0] one_min;
    logic [WidthBits-1:0] one_max;
    logic [WidthBits-1:0] end_min;
    logic [WidthBits-1:0] end_max;
    logic [WidthBits-1:0] sync_min;
    logic [WidthBits-1:0] sync_max;
  } window_cfg_t;

endpackage

`default_nettype wire

// File: hdl/irpd_classify.sv
// Pulse width classifier: matches a falling-edge width against the windows.
`timescale 1ns / 1ps
`default_nettype none

module irpd_classify (
  input  logic [irpd_pkg::WidthBits-1:0] width_i,
  input  logic                           armed_i,
  input  irpd_pkg::window_cfg_t          cfg_i,
  output irpd_pkg::pulse_kind_e          kind_o
);
  import irpd_pkg::*;

  logic in_zero;
  logic in_one;
  logic in_end;
  logic in_sync;

  // Compare against every window at once
  assign in_zero = (width_i > cfg_i.zero_min) && (width_i < cfg_i.zero_max);
  assign in_one  = (width_i > cfg_i.one_min)  && (width_i < cfg_i.one_max);
  assign in_end  = (width_i > cfg_i.end_min)  && (width_i < cfg_i.end_max);
  assign in_sync = (width_i > cfg_i.sync_min) && (width_i < cfg_i.sync_max);

  // Pick the kind: bit and end windows once armed, zero first; sync only before
  always_comb begin
    if (armed_i) begin
      priority if (in_zero) begin
        kind_o = KindZero;
      end else if (in_one) begin
        kind_o = KindOne;
      end else if (in_end) begin
        kind_o = KindEnd;
      end else begin
        kind_o = KindMiss;
      end
    end else begin
      kind_o = in_sync ? KindSync : KindMiss;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ir_remote_pulse_decoder.sv
// Top level of the IR remote pulse decoder: input stage, decode, result register.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i / in_stall_o   in_item_i  (in_item_t)
//   out      from block out_valid_o / out_stall_i out_item_o (out_item_t)
//   cfg      to block   cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One event per cycle unless stalled; each passes the input and result registers.
// The decode state is updated in the cycle an event leaves the input register,
// so the next event in the input register sees it with no bubble.
// rst_ni clears control state and restores the window bounds at once; no sweep.
// A stalled output holds its result and backs up into the input register.
`timescale 1ns / 1ps
`default_nettype none

module ir_remote_pulse_decoder #(
  parameter int unsigned CODE_BITS = irpd_pkg::CodeBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  irpd_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output irpd_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [irpd_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [irpd_pkg::WidthBits-1:0]    cfg_wdata_i
);
  import irpd_pkg::*;

  window_cfg_t cfg_q;

  logic     in_valid_q;
  in_item_t in_item_q;

  logic                 expect_falling_q, expect_falling_d;
  logic                 armed_q, armed_d;
  logic                 done_q, done_d;
  logic [CODE_BITS-1:0] code_q, code_d;

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic        advance;
  logic        take_in;
  pulse_kind_e fall_kind;
  pulse_kind_e kind;
  logic [CodeWordWidth-1:0] code_word;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_min <= ZeroMinReset;
      cfg_q.zero_max <= ZeroMaxReset;
      cfg_q.one_min  <= OneMinReset;
      cfg_q.one_max  <= OneMaxReset;
      cfg_q.end_min  <= EndMinReset;
      cfg_q.end_max  <= EndMaxReset;
      cfg_q.sync_min <= SyncMinReset;
      cfg_q.sync_max <= SyncMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgZeroMin: cfg_q.zero_min <= cfg_wdata_i;
        CfgZeroMax: cfg_q.zero_max <= cfg_wdata_i;
        CfgOneMin:  cfg_q.one_min  <= cfg_wdata_i;
        CfgOneMax:  cfg_q.one_max  <= cfg_wdata_i;
        CfgEndMin:  cfg_q.end_min  <= cfg_wdata_i;
        CfgEndMax:  cfg_q.end_max  <= cfg_wdata_i;
        CfgSyncMin: cfg_q.sync_min <= cfg_wdata_i;
        CfgSyncMax: cfg_q.sync_max <= cfg_wdata_i;
        default:    cfg_q          <= cfg_q;
      endcase
    end
  end

  // Handshake: decode when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in || advance) begin
      in_valid_q <= take_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_item_q <= in_item_i;
    end
  end

  irpd_classify u_classify (
    .width_i (in_item_q.capture_count),
    .armed_i (armed_q),
    .cfg_i   (cfg_q),
    .kind_o  (fall_kind)
  );

  // Next decode state for the event in the input register
  always_comb begin
    expect_falling_d = !expect_falling_q;
    armed_d          = armed_q;
    code_d           = code_q;
    done_d           = done_q && !in_item_q.ack_done;
    kind             = KindRise;
    if (expect_falling_q) begin
      kind = fall_kind;
      unique case (fall_kind)
        KindZero: code_d = {code_q[CODE_BITS-2:0], 1'b0};
        KindOne:  code_d = {code_q[CODE_BITS-2:0], 1'b1};
        KindEnd: begin
          done_d  = 1'b1;
          armed_d = 1'b0;
        end
        KindSync: armed_d = 1'b1;
        default:  armed_d = armed_q;
      endcase
    end
  end

  // Report the low bits of the code register, zero extended when it is narrow
  if (CODE_BITS >= CodeWordWidth) begin : g_code_wide
    assign code_word = code_d[CodeWordWidth-1:0];
  end else begin : g_code_narrow
    assign code_word = {{(CodeWordWidth - CODE_BITS){1'b0}}, code_d};
  end

  always_comb begin
    out_item_d.code_word  = code_word;
    out_item_d.frame_done = done_d;
    out_item_d.sync_armed = armed_d;
    out_item_d.pulse_kind = kind;
  end

  // Decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_falling_q <= 1'b0;
      armed_q          <= 1'b0;
      done_q           <= 1'b0;
      code_q           <= '0;
    end else if (advance) begin
      expect_falling_q <= expect_falling_d;
      armed_q          <= armed_d;
      done_q           <= done_d;
      code_q           <= code_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: hdl/irpd_checker.sv
// Port-level checker for the IR remote pulse decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irpd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire irpd_pkg::out_item_t out_item_o
);
  import irpd_pkg::*;

  // Hold a stalled result
  `ASSERT_PORT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `ASSERT_PORT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_item_o))

  // An end pulse completes the frame and disarms
  `ASSERT_PORT(a_end_done, out_valid_o && out_item_o.pulse_kind == KindEnd |->
               out_item_o.frame_done && !out_item_o.sync_armed)

  // A sync pulse arms the decoder
  `ASSERT_PORT(a_sync_arms, out_valid_o && out_item_o.pulse_kind == KindSync |->
               out_item_o.sync_armed)

  // A bit pulse only arrives while armed and sets the low code bit to its value
  `ASSERT_PORT(a_bit_armed, out_valid_o && (out_item_o.pulse_kind == KindZero ||
               out_item_o.pulse_kind == KindOne) |-> out_item_o.sync_armed &&
               out_item_o.code_word[0] == (out_item_o.pulse_kind == KindOne))

endmodule

bind ir_remote_pulse_decoder irpd_checker u_irpd_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench of the IR remote pulse decoder: edge stimulus, prediction, result check.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import irpd_pkg::*;

  localparam int unsigned WatchdogLimit = 200;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned DrainCycles   = 4;

  // Register indexes in list order
  localparam logic [CfgIndexBits-1:0] RegOrder [8] = '{
    CfgZeroMin, CfgZeroMax, CfgOneMin, CfgOneMax,
    CfgEndMin, CfgEndMax, CfgSyncMin, CfgSyncMax
  };

  // Tracks decoder state per accepted edge and holds the results still to come
  class pulse_scoreboard;
    window_cfg_t              windows;
    logic                     expect_fall;
    logic                     armed;
    logic                     done;
    logic [CodeWordWidth-1:0] code_q;
    out_item_t                expected_q[$];
    int unsigned              errors;

    function new();
      windows.zero_min = ZeroMinReset;
      windows.zero_max = ZeroMaxReset;
      windows.one_min  = OneMinReset;
      windows.one_max  = OneMaxReset;
      windows.end_min  = EndMinReset;
      windows.end_max  = EndMaxReset;
      windows.sync_min = SyncMinReset;
      windows.sync_max = SyncMaxReset;
      expect_fall = 1'b0;
      armed       = 1'b0;
      done        = 1'b0;
      code_q      = '0;
      errors      = 0;
    endfunction

    function void write_cfg(logic [CfgIndexBits-1:0] idx, logic [WidthBits-1:0] val);
      case (idx)
        CfgZeroMin: windows.zero_min = val;
        CfgZeroMax: windows.zero_max = val;
        CfgOneMin:  windows.one_min  = val;
        CfgOneMax:  windows.one_max  = val;
        CfgEndMin:  windows.end_min  = val;
        CfgEndMax:  windows.end_max  = val;
        CfgSyncMin: windows.sync_min = val;
        CfgSyncMax: windows.sync_max = val;
        default: ;
      endcase
    endfunction

    // Both bounds are exclusive
    function bit in_window(logic [WidthBits-1:0] w, logic [WidthBits-1:0] lo,
                           logic [WidthBits-1:0] hi);
      return (w > lo) && (w < hi);
    endfunction

    // Advance the decode state by one edge and queue the result it produces
    function void note_input(in_item_t item);
      out_item_t            res;
      pulse_kind_e          kind;
      logic [WidthBits-1:0] w;
      w = item.capture_count;
      if (item.ack_done) done = 1'b0;
      if (!expect_fall) begin
        expect_fall = 1'b1;
        kind = KindRise;
      end else begin
        expect_fall = 1'b0;
        kind = KindMiss;
        if (armed) begin
          if (in_window(w, windows.zero_min, windows.zero_max)) begin
            code_q = {code_q[CodeWordWidth-2:0], 1'b0};
            kind = KindZero;
          end else if (in_window(w, windows.one_min, windows.one_max)) begin
            code_q = {code_q[CodeWordWidth-2:0], 1'b1};
            kind = KindOne;
          end else if (in_window(w, windows.end_min, windows.end_max)) begin
            done  = 1'b1;
            armed = 1'b0;
            kind  = KindEnd;
          end
        end else if (in_window(w, windows.sync_min, windows.sync_max)) begin
          armed = 1'b1;
          kind  = KindSync;
        end
      end
      res.code_word  = code_q;
      res.frame_done = done;
      res.sync_armed = armed;
      res.pulse_kind = kind;
      expected_q.push_back(res);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("result with nothing expected: code %h done %b armed %b kind %0d",
                   got.code_word, got.frame_done, got.sync_armed, got.pulse_kind);
        return;
      end
      want = expected_q.pop_front();
      if (got.code_word !== want.code_word || got.frame_done !== want.frame_done ||
          got.sync_armed !== want.sync_armed || got.pulse_kind !== want.pulse_kind) begin
        errors++;
        if (errors <= ReportLimit)
          $display("mismatch: code %h/%h done %b/%b armed %b/%b kind %0d/%0d (exp/act)",
                   want.code_word, got.code_word, want.frame_done, got.frame_done,
                   want.sync_armed, got.sync_armed, want.pulse_kind, got.pulse_kind);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  in_item_t                in_item_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  out_item_t               out_item_o;
  logic                    cfg_we_i;
  logic [CfgIndexBits-1:0] cfg_index_i;
  logic [WidthBits-1:0]    cfg_wdata_i;

  logic [WidthBits-1:0] bounds [8];
  bit                   idle_on     = 1'b1;
  bit                   quiet_tail  = 1'b0;
  int unsigned          stall_left  = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          n_sent      = 0;
  pulse_scoreboard      sb = new();

  ir_remote_pulse_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the output in random bursts, started only while idling is enabled
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Observe transactions on both channels; end the run if traffic stops
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function logic rand_ack();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function logic [WidthBits-1:0] rand_count();
    return WidthBits'($urandom_range(0, 65535));
  endfunction

  // Width strictly inside a window, or any width when the window is empty
  function logic [WidthBits-1:0] pick_inside(logic [WidthBits-1:0] lo, logic [WidthBits-1:0] hi);
    if (int'(hi) > int'(lo) + 1)
      return WidthBits'($urandom_range(int'(lo) + 1, int'(hi) - 1));
    return rand_count();
  endfunction

  // Present one edge event and hold it until accepted
  task automatic drive_edge(input logic [WidthBits-1:0] cnt, input logic ack);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= {cnt, ack};
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  // Rising edge with a random count, then the falling edge carrying the width
  task automatic pulse(input logic [WidthBits-1:0] width, input logic ack_rise,
                       input logic ack_fall);
    drive_edge(rand_count(), ack_rise);
    drive_edge(width, ack_fall);
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write all eight window bounds while the block is idle
  task automatic load_windows(input logic [WidthBits-1:0] z0, z1, o0, o1, e0, e1, s0, s1);
    settle();
    bounds = '{z0, z1, o0, o1, e0, e1, s0, s1};
    foreach (RegOrder[k]) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= RegOrder[k];
      cfg_wdata_i <= bounds[k];
      sb.write_cfg(RegOrder[k], bounds[k]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed frames with random bits, mixed with noise and broken frames
  task automatic run_frames(input int unsigned quota);
    int unsigned stop;
    int unsigned nbits;
    int unsigned r;
    int unsigned w;
    stop = n_sent + quota;
    while (n_sent < stop) begin
      idle_on = !quiet_tail && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        pulse(pick_inside(bounds[6], bounds[7]), rand_ack(), rand_ack());
        nbits = (r == 6) ? $urandom_range(0, 40) : 32;
        for (int k = 0; k < nbits; k++) begin
          if ($urandom_range(0, 1)) pulse(pick_inside(bounds[2], bounds[3]), rand_ack(), rand_ack());
          else pulse(pick_inside(bounds[0], bounds[1]), rand_ack(), rand_ack());
        end
        // leave some frames without an end pulse
        if (r != 5) pulse(pick_inside(bounds[4], bounds[5]), rand_ack(), rand_ack());
      end else if (r == 7) begin
        pulse(rand_count(), rand_ack(), rand_ack());
      end else if (r == 8) begin
        // a lone edge shifts the rise/fall alternation
        drive_edge(rand_count(), rand_ack());
      end else begin
        w = 2 * $urandom_range(0, 3);
        pulse(pick_inside(bounds[w], bounds[w + 1]), rand_ack(), rand_ack());
      end
    end
  endtask

  initial begin
    int unsigned base [4];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgZeroMin;
    cfg_wdata_i = '0;
    bounds = '{ZeroMinReset, ZeroMaxReset, OneMinReset, OneMaxReset,
               EndMinReset, EndMaxReset, SyncMinReset, SyncMaxReset};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed edges at the reset windows
    pulse(16'd0, 1'b1, 1'b1);            // acknowledge with nothing to clear
    drive_edge(16'hFFFF, 1'b0);          // rising count is ignored
    drive_edge(16'd30, 1'b0);            // bit width while not armed
    pulse(16'hFFFF, 1'b0, 1'b0);
    pulse(16'd300, 1'b0, 1'b0);          // sync bounds are exclusive
    pulse(16'd450, 1'b0, 1'b0);
    pulse(16'd301, 1'b0, 1'b0);          // arm
    pulse(16'd449, 1'b0, 1'b0);          // sync width while armed
    pulse(16'd25, 1'b0, 1'b0);
    pulse(16'd26, 1'b0, 1'b0);
    pulse(16'd54, 1'b0, 1'b0);
    pulse(16'd55, 1'b0, 1'b0);
    pulse(16'd139, 1'b0, 1'b0);
    pulse(16'd156, 1'b0, 1'b0);          // end of frame
    pulse(16'd320, 1'b0, 1'b0);
    pulse(16'd101, 1'b0, 1'b0);          // bit while frame done is still set
    drive_edge(16'd0, 1'b1);             // acknowledge on a rising edge
    drive_edge(16'd199, 1'b0);
    pulse(16'd60, 1'b0, 1'b1);           // acknowledge on a falling edge

    // Random phases over several window settings
    load_windows(16'd25, 16'd55, 16'd100, 16'd140, 16'd155, 16'd200, 16'd300, 16'd450);
    run_frames(300);
    // overlapping windows: zero wins over one, one over end
    load_windows(16'd10, 16'd200, 16'd50, 16'd300, 16'd100, 16'd400, 16'd0, 16'hFFFF);
    run_frames(200);
    // narrowest windows next to the field limits
    load_windows(16'd0, 16'd3, 16'd2, 16'd5, 16'd4, 16'd7, 16'hFFFD, 16'hFFFF);
    run_frames(200);
    // empty bit and end windows
    load_windows(16'd100, 16'd101, 16'hFFFF, 16'd0, 16'd7, 16'd8, 16'd1000, 16'd2000);
    run_frames(60);
    load_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_frames(30);
    load_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_frames(30);
    foreach (base[k]) base[k] = $urandom_range(0, 63535);
    load_windows(WidthBits'(base[0]), WidthBits'(base[0] + $urandom_range(0, 2000)),
                 WidthBits'(base[1]), WidthBits'(base[1] + $urandom_range(0, 2000)),
                 WidthBits'(base[2]), WidthBits'(base[2] + $urandom_range(0, 2000)),
                 WidthBits'(base[3]), WidthBits'(base[3] + $urandom_range(0, 2000)));
    run_frames(200);
    // final stretch with no idling
    quiet_tail = 1'b1;
    idle_on    = 1'b0;
    load_windows(16'd25, 16'd55, 16'd100, 16'd140, 16'd155, 16'd200, 16'd300, 16'd450);
    run_frames(250);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/irpd_pkg.sv
hdl/irpd_classify.sv
hdl/ir_remote_pulse_decoder.sv
hdl/irpd_checker.sv
tb/sv/testbench.sv
